@@ rtl/core/wss_pkg.sv @@
// Shared types and constants for the windowed sample statistics block.
// Used by wss_ctrl, wss_dp and windowed_sample_statistics; no dependencies.
package wss_pkg;

  localparam int WINDOW_DEF = 360;
  localparam int SAMPLE_W   = 16;
  localparam int STAMP_W    = 32;
  localparam int HELD_W     = 9;

  localparam logic signed [SAMPLE_W-1:0] RESET_MAX = -16'sd9999;
  localparam logic signed [SAMPLE_W-1:0] RESET_MIN = 16'sd9999;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_PREP,
    S_DIV,
    S_DONE
  } wss_state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic prep;
    logic step;
    logic emit;
  } wss_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } wss_sts_t;

endpackage

@@ rtl/core/wss_ctrl.sv @@
// Controller state machine: sequences accept, window update, divide and result load.
// Depends on wss_pkg; drives wss_dp through wss_cmd_t and reads wss_sts_t.
module wss_ctrl
  import wss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  wss_sts_t sts,
  output wss_cmd_t cmd
);

  wss_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_UPDATE;
      end
      S_UPDATE: state_nxt = S_PREP;
      S_PREP:   state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_UPDATE: cmd.update = 1'b1;
      S_PREP:   cmd.prep   = 1'b1;
      S_DIV:    cmd.step   = 1'b1;
      S_DONE:   cmd.emit   = sts.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/wss_dp.sv @@
// Datapath: sample ring memory, running sum, max/min tracking, serial divider
// and output register. Depends on wss_pkg; commanded by wss_ctrl.
module wss_dp
  import wss_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wss_cmd_t                   cmd,
  output wss_sts_t                   sts,
  input  logic signed [SAMPLE_W-1:0] in_humidity,
  input  logic [STAMP_W-1:0]         in_sample_time,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_average,
  output logic signed [SAMPLE_W-1:0] out_maximum,
  output logic signed [SAMPLE_W-1:0] out_minimum,
  output logic [STAMP_W-1:0]         out_maximum_time,
  output logic [STAMP_W-1:0]         out_minimum_time,
  output logic [HELD_W-1:0]          out_held_count
);

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW);
  localparam logic [PTR_W:0]    WIN_SLOT = (PTR_W + 1)'(WINDOW);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(WINDOW - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic signed [SAMPLE_W-1:0] mem [WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [STAMP_W-1:0]         stamp_r;
  logic [PTR_W-1:0]           oldest_r;
  logic [CNT_W-1:0]           fill_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] max_r, min_r;
  logic [STAMP_W-1:0]         max_time_r, min_time_r;

  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_average_r, out_maximum_r, out_minimum_r;
  logic [STAMP_W-1:0]         out_maximum_time_r, out_minimum_time_r;
  logic [HELD_W-1:0]          out_held_count_r;

  logic                    full;
  logic [PTR_W:0]          slot_ext;
  logic [PTR_W-1:0]        wr_addr;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0]        sum_mag;
  logic [CNT_W:0]          rem_sh;
  logic                    fits;
  logic [CNT_W-1:0]        rem_nxt;
  logic [SAMPLE_W-1:0]     avg_mag;

  assign full     = (fill_r == WIN_CNT);
  assign slot_ext = {1'b0, oldest_r} + (PTR_W + 1)'(fill_r);
  assign wr_addr  = full ? oldest_r
                  : (slot_ext >= WIN_SLOT) ? PTR_W'(slot_ext - WIN_SLOT)
                  : slot_ext[PTR_W-1:0];
  assign sum_nxt  = full ? (sum_r + SUM_W'(sample_r) - SUM_W'(rd_data_r))
                         : (sum_r + SUM_W'(sample_r));
  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign fits     = (rem_sh >= {1'b0, fill_r});
  assign rem_nxt  = fits ? CNT_W'(rem_sh - {1'b0, fill_r}) : rem_sh[CNT_W-1:0];
  assign avg_mag  = quo_r[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    rd_data_r <= mem[oldest_r];
    if (cmd.update) begin
      mem[wr_addr] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_humidity;
      stamp_r  <= in_sample_time;
    end
    if (cmd.prep) begin
      rem_r  <= '0;
      quo_r  <= sum_mag;
      neg_r  <= sum_r[SUM_W-1];
      step_r <= LAST_STEP;
    end else if (cmd.step) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[SUM_W-2:0], fits};
      step_r <= step_r - 1'b1;
    end
    if (cmd.emit) begin
      out_average_r      <= neg_r ? -avg_mag : avg_mag;
      out_maximum_r      <= max_r;
      out_minimum_r      <= min_r;
      out_maximum_time_r <= max_time_r;
      out_minimum_time_r <= min_time_r;
      out_held_count_r   <= HELD_W'(fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      max_r       <= RESET_MAX;
      min_r       <= RESET_MIN;
      max_time_r  <= '0;
      min_time_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        sum_r <= sum_nxt;
        if (full) begin
          oldest_r <= (oldest_r == LAST_PTR) ? '0 : oldest_r + 1'b1;
        end else begin
          fill_r <= fill_r + 1'b1;
        end
        if (sample_r > max_r) begin
          max_r      <= sample_r;
          max_time_r <= stamp_r;
        end
        if (sample_r < min_r) begin
          min_r      <= sample_r;
          min_time_r <= stamp_r;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_last = (step_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_average      = out_average_r;
  assign out_maximum      = out_maximum_r;
  assign out_minimum      = out_minimum_r;
  assign out_maximum_time = out_maximum_time_r;
  assign out_minimum_time = out_minimum_time_r;
  assign out_held_count   = out_held_count_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_CNT)
    else $error("fill count beyond window");

  a_oldest_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r != '0 |-> full)
    else $error("oldest pointer moved before ring filled");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != $past(fill_r) |-> fill_r == $past(fill_r) + 1'b1)
    else $error("fill count jumped");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending item");

endmodule

@@ rtl/core/windowed_sample_statistics.sv @@
// Windowed sample statistics: moving average over the last WINDOW samples
// with all-time maximum and minimum tracking.
//
// Input channel (in_valid/in_ready) carries one item: a signed humidity sample
// and its 32-bit timestamp. Output channel (out_valid/out_ready) returns one
// item per input: truncated average of the held samples, all-time max and min
// with their timestamps, and the number of samples held.
// Each item runs a window update, a divider setup, a restoring divider that
// retires one quotient bit per cycle, and a result load that waits until the
// output register is free; in_ready is high again the cycle after the load.
// The block takes one item at a time: in_ready stays low from acceptance until
// the result is loaded. The serial divider limits the rate of items.
// One result waits in the output register while the next item is accepted;
// if the receiver stalls, the finished next result holds until it is taken.
// Reset (rst_n low, synchronous) empties the window, clears the sum, sets the
// maximum to -9999 and minimum to 9999 with zero timestamps; the sample memory
// itself is not cleared, since entries are read only after being written.
// Depends on wss_pkg, wss_ctrl and wss_dp.
module windowed_sample_statistics
  import wss_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_humidity,
  input  logic [STAMP_W-1:0]         in_sample_time,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_average,
  output logic signed [SAMPLE_W-1:0] out_maximum,
  output logic signed [SAMPLE_W-1:0] out_minimum,
  output logic [STAMP_W-1:0]         out_maximum_time,
  output logic [STAMP_W-1:0]         out_minimum_time,
  output logic [HELD_W-1:0]          out_held_count
);

  wss_cmd_t cmd;
  wss_sts_t sts;

  wss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wss_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_humidity      (in_humidity),
    .in_sample_time   (in_sample_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average      (out_average),
    .out_maximum      (out_maximum),
    .out_minimum      (out_minimum),
    .out_maximum_time (out_maximum_time),
    .out_minimum_time (out_minimum_time),
    .out_held_count   (out_held_count)
  );

endmodule
